// ===== hdl/tld_pkg.sv =====
package tld_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] key_char;
    logic       ctrl_held;
  } tld_in_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] out_char;
    logic [8:0] erase_count;
    logic [1:0] signal_code;
    logic       last;
  } tld_out_t;

  localparam logic [2:0] K_ECHO   = 3'd0;
  localparam logic [2:0] K_ERASE  = 3'd1;
  localparam logic [2:0] K_SIGNAL = 3'd2;
  localparam logic [2:0] K_BYTE   = 3'd3;
  localparam logic [2:0] K_EMPTY  = 3'd4;
  localparam logic [2:0] K_EOF    = 3'd5;
  localparam logic [2:0] K_WAKE   = 3'd6;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_INTR  = 3'd1;
  localparam logic [2:0] REG_QUIT  = 3'd2;
  localparam logic [2:0] REG_SUSP  = 3'd3;
  localparam logic [2:0] REG_ERASE = 3'd4;
  localparam logic [2:0] REG_KILL  = 3'd5;
  localparam logic [2:0] REG_EOF   = 3'd6;
  localparam logic [2:0] REG_FG    = 3'd7;

  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_DEL = 8'd127;
  localparam logic [7:0] CH_CARET = 8'h5E;

endpackage

// ===== hdl/terminal_line_discipline.sv =====
// Terminal line discipline: canonical/raw keystroke processing and a read queue.
// Requests arrive on in_valid/in_data with in_stall driven back by this block;
// results leave on out_valid/out_data with out_stall from the receiver. Each
// request yields zero to four results, the final one marked by last. Register
// writes use cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is tied high and
// registers are meant to be written only while no request is in work.
// A keystroke with results and no flush goes from acceptance to the emit state,
// where its results enter the output register one at a time. A read of a
// non-empty queue passes through acceptance, a queue memory read state, then
// the result; a read of an empty queue goes straight to its result. A newline
// or end-of-file flush copies the line store into the read queue one byte per
// cycle through the single read port of the line memory before the first
// result; the bytes copied include the newline when it was stored. Input is
// stalled while a request is in work. Results held by a stalled receiver stay
// in the output register; the block proceeds to its next result only when taken.
// Reset (rst, synchronous) empties the line and the queue, clears the
// end-of-file mark and restores all registers to their defaults; memory
// contents are left as they are since unwritten entries are never read.
module terminal_line_discipline #(
  parameter int LINE_DEPTH  = 256,
  parameter int QUEUE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tld_pkg::tld_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tld_pkg::tld_out_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import tld_pkg::*;

  localparam int LAW = $clog2(LINE_DEPTH);
  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int LCW = $clog2(LINE_DEPTH + 1);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EMIT  = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_RDQ   = 3'd3;

  // Configuration registers.
  logic [3:0] mode_flags;
  logic [7:0] intr_char, quit_char, susp_char, erase_char, kill_char, eof_char;
  logic       fg_group_set;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_flags <= 4'd15; intr_char <= 8'd3; quit_char <= 8'd28;
      susp_char <= 8'd26; erase_char <= 8'd8; kill_char <= 8'd21;
      eof_char <= 8'd4; fg_group_set <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:  mode_flags   <= cfg_data[3:0];
        REG_INTR:  intr_char    <= cfg_data;
        REG_QUIT:  quit_char    <= cfg_data;
        REG_SUSP:  susp_char    <= cfg_data;
        REG_ERASE: erase_char   <= cfg_data;
        REG_KILL:  kill_char    <= cfg_data;
        REG_EOF:   eof_char     <= cfg_data;
        REG_FG:    fg_group_set <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Control state.
  logic [2:0]     state;
  logic [LCW-1:0] line_length;
  logic [QAW-1:0] queue_head, queue_tail;
  logic [QCW-1:0] queue_count;
  logic           eof_seen;

  // Pending result list for the current request (up to four).
  tld_out_t       res [4];
  logic [2:0]     res_n, res_i;
  logic           do_flush;
  logic [LCW-1:0] flush_len, flush_i;

  // Memories.
  logic           l_we;
  logic [LAW-1:0] l_waddr, l_raddr;
  logic [7:0]     l_wdata, l_rdata;
  logic           q_we;
  logic [QAW-1:0] q_waddr;
  logic [7:0]     q_wdata, q_rdata;

  tld_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );
  tld_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(queue_head), .rdata(q_rdata)
  );

  assign in_stall = (state != S_IDLE);
  wire in_acc  = in_valid && !in_stall;
  wire out_acc = out_valid && !out_stall;

  // Queue pointers wrap at the queue depth.
  wire [QAW-1:0] head_inc = (queue_head == QAW'(QUEUE_DEPTH - 1)) ? '0
                            : queue_head + QAW'(1);
  wire [QAW-1:0] tail_inc = (queue_tail == QAW'(QUEUE_DEPTH - 1)) ? '0
                            : queue_tail + QAW'(1);

  // Keystroke mapping.
  logic [7:0] kc;
  always_comb begin
    kc = in_data.key_char;
    if (in_data.ctrl_held && kc >= 8'h41 && kc <= 8'h5A) kc = kc - 8'h40;
    else if (in_data.ctrl_held && kc >= 8'h61 && kc <= 8'h7A) kc = kc - 8'h60;
    if (mode_flags[0] && kc == CH_CR) kc = CH_NL;
  end

  function automatic tld_out_t mk(input logic [2:0] k, input logic [7:0] c,
                                  input logic [8:0] n, input logic [1:0] s);
    tld_out_t r;
    r.result_kind = k; r.out_char = c; r.erase_count = n;
    r.signal_code = s; r.last = 1'b0;
    return r;
  endfunction

  // Decode of one request into a result list and state changes.
  tld_out_t       d_res [4];
  logic [2:0]     d_n;
  logic           d_flush, d_line_we, d_q_we, d_eof_set, d_rd;
  logic [LCW-1:0] d_len;
  logic [7:0]     d_sigl;
  logic [1:0]     d_sigc;
  logic           d_sig;
  logic           echo;

  always_comb begin
    for (int i = 0; i < 4; i++) d_res[i] = mk(K_ECHO, 8'd0, 9'd0, 2'd0);
    d_n = 3'd0; d_flush = 1'b0; d_line_we = 1'b0; d_q_we = 1'b0;
    d_eof_set = 1'b0; d_rd = 1'b0; d_len = line_length;
    d_sig = 1'b0; d_sigl = 8'h43; d_sigc = 2'd0;
    echo = mode_flags[3];
    if (in_data.req_type) begin
      d_rd = 1'b1;
      d_n = 3'd1;
      if (queue_count == '0) begin
        d_res[0] = mk(eof_seen ? K_EOF : K_EMPTY, 8'd0, 9'd0, 2'd0);
      end
    end else if (kc != 8'd0) begin
      if (mode_flags[1] && kc == intr_char) begin
        d_sig = 1'b1;
      end else if (mode_flags[1] && kc == quit_char) begin
        d_sig = 1'b1; d_sigl = 8'h5C; d_sigc = 2'd1;
      end else if (mode_flags[1] && kc == susp_char) begin
        d_sig = 1'b1; d_sigl = 8'h5A; d_sigc = 2'd2;
      end
      if (d_sig) begin
        d_len = '0;
        if (echo) begin
          d_res[0] = mk(K_ECHO, CH_CARET, 9'd0, 2'd0);
          d_res[1] = mk(K_ECHO, d_sigl, 9'd0, 2'd0);
          d_res[2] = mk(K_ECHO, CH_NL, 9'd0, 2'd0);
          d_n = 3'd3;
        end
        if (fg_group_set) begin
          d_res[d_n[1:0]] = mk(K_SIGNAL, 8'd0, 9'd0, d_sigc);
          d_n = d_n + 3'd1;
        end
      end else if (mode_flags[2]) begin
        if (kc == erase_char || kc == CH_DEL) begin
          if (line_length != '0) begin
            d_len = line_length - LCW'(1);
            if (echo) begin
              d_res[0] = mk(K_ECHO, CH_BS, 9'd0, 2'd0);
              d_res[1] = mk(K_ECHO, CH_SP, 9'd0, 2'd0);
              d_res[2] = mk(K_ECHO, CH_BS, 9'd0, 2'd0);
              d_n = 3'd3;
            end
          end
        end else if (kc == kill_char) begin
          if (line_length != '0 && echo) begin
            d_res[0] = mk(K_ERASE, 8'd0, 9'(line_length), 2'd0);
            d_n = 3'd1;
          end
          d_len = '0;
        end else if (kc == eof_char) begin
          d_res[0] = mk(K_WAKE, 8'd0, 9'd0, 2'd0);
          d_n = 3'd1;
          if (line_length == '0) d_eof_set = 1'b1;
          else d_flush = 1'b1;
        end else begin
          if (line_length < LCW'(LINE_DEPTH)) begin
            d_line_we = 1'b1;
            d_len = line_length + LCW'(1);
          end
          if (echo) begin
            d_res[0] = mk(K_ECHO, kc, 9'd0, 2'd0);
            d_n = 3'd1;
          end
          if (kc == CH_NL) begin
            d_res[d_n[1:0]] = mk(K_WAKE, 8'd0, 9'd0, 2'd0);
            d_n = d_n + 3'd1;
            d_flush = 1'b1;
          end
        end
      end else begin
        d_q_we = 1'b1;
        if (echo) begin
          d_res[0] = mk(K_ECHO, kc, 9'd0, 2'd0);
          d_n = 3'd1;
        end
        d_res[d_n[1:0]] = mk(K_WAKE, 8'd0, 9'd0, 2'd0);
        d_n = d_n + 3'd1;
      end
    end
  end

  wire q_full = (queue_count == QCW'(QUEUE_DEPTH));

  // Memory write ports.
  always_comb begin
    l_we = in_acc && !in_data.req_type && d_line_we;
    l_waddr = line_length[LAW-1:0];
    l_wdata = kc;
    l_raddr = flush_i[LAW-1:0];
    q_we = 1'b0; q_wdata = kc;
    q_waddr = queue_tail;
    if (in_acc && !in_data.req_type && d_q_we && !q_full) q_we = 1'b1;
    if (state == S_FLUSH && flush_i != '0 && !q_full) begin
      q_we = 1'b1; q_wdata = l_rdata;
    end
  end

  // Next result for the output register, with its last flag.
  tld_out_t emit_r;
  always_comb begin
    emit_r = res[res_i[1:0]];
    emit_r.last = (res_i + 3'd1 == res_n);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; line_length <= '0; queue_head <= '0; queue_tail <= '0;
      queue_count <= '0; eof_seen <= 1'b0; out_valid <= 1'b0;
      res_n <= '0; res_i <= '0; do_flush <= 1'b0; flush_i <= '0;
      flush_len <= '0;
    end else begin
      if (out_acc && state != S_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            for (int i = 0; i < 4; i++) res[i] <= d_res[i];
            res_n <= d_n; res_i <= '0;
            line_length <= d_flush ? '0 : d_len;
            flush_len <= d_line_we ? d_len : line_length;
            flush_i <= '0;
            do_flush <= d_flush;
            if (d_eof_set) eof_seen <= 1'b1;
            if (q_we) begin
              queue_tail <= tail_inc;
              queue_count <= queue_count + QCW'(1);
            end
            if (d_rd) begin
              if (queue_count == '0) begin
                eof_seen <= 1'b0;
                state <= S_EMIT;
              end else begin
                queue_head <= head_inc;
                queue_count <= queue_count - QCW'(1);
                state <= S_RDQ;
              end
            end else if (d_flush) begin
              state <= S_FLUSH;
            end else if (d_n != '0) begin
              state <= S_EMIT;
            end
          end
        end
        S_RDQ: begin
          res[0] <= mk(K_BYTE, q_rdata, 9'd0, 2'd0);
          state <= S_EMIT;
        end
        S_FLUSH: begin
          // flush_i leads the memory data, which comes through the registered read port.
          if (q_we) begin
            queue_tail <= tail_inc;
            queue_count <= queue_count + QCW'(1);
          end
          if (flush_i == flush_len) state <= S_EMIT;
          else flush_i <= flush_i + LCW'(1);
        end
        S_EMIT: begin
          if (!out_valid || out_acc) begin
            out_data <= emit_r;
            out_valid <= 1'b1;
            res_i <= res_i + 3'd1;
            if (res_i + 3'd1 == res_n) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count: assert property (@(posedge clk) disable iff (rst)
    queue_count <= QCW'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_len: assert property (@(posedge clk) disable iff (rst)
    line_length <= LCW'(LINE_DEPTH)) else $error("line length overflow");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input not stalled while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");

endmodule

// ===== hdl/tld_ram.sv =====
module tld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
